// ----- sv/md5_pkg.sv -----
// MD5 package: initial chaining value, sine table, rotation amounts and
// the per-step helper functions used by the digest core.
// No dependencies.
package md5_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BufDep = 16;
  localparam int unsigned LenW   = 64;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [WordW-1:0] IV_TAB [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [WordW-1:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Indexed by {round, step[1:0]}
  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_idx(input logic [5:0] step);
    logic [7:0] s8;
    logic [7:0] p;
    s8 = {2'b00, step};
    unique case (step[5:4])
      2'd0: p = s8;
      2'd1: p = 8'd1 + 8'd5 * s8;
      2'd2: p = 8'd5 + 8'd3 * s8;
      2'd3: p = 8'd7 * s8;
    endcase
    return p[3:0];
  endfunction

  function automatic logic [WordW-1:0] round_fn(input logic [1:0] rnd,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c,
                                                input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    unique case (rnd)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] n);
    logic [2*WordW-1:0] w;
    w = {x, x} << n;
    return w[2*WordW-1:WordW];
  endfunction

endpackage

// ----- sv/md5_message_digest.sv -----
// MD5 digest core: byte packing, block buffer memory, one-step-per-cycle
// compression sequencer and digest output.
// Depends on md5_pkg.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with data_byte_i, byte_present_i
//   and end_of_message_i. Each accepted word appends at most one byte; a
//   word with end_of_message_i set closes the message and pads it.
//   Output channel: out_valid_o / out_stall_i carries the four digest words
//   A, B, C, D in order, last_word_o marking D.
//   A byte word is taken while the core is idle. Every 64th byte starts
//   a compression: prefetch states ST_CMP_P0 and ST_CMP_P1 for the single
//   read port of the 16-word block memory, 64 steps, one feed-forward add.
//   An ending word passes ST_PAD, ST_LEN_LO, ST_LEN_HI and one or two
//   compressions; digest words then leave one per cycle unless stalled.
//   in_stall_o is high whenever the core is not waiting for a byte.
//   While the receiver stalls, the current digest word holds and the core
//   takes no input. After the word D is taken all state returns to the
//   initial chaining value and the next message may start.
//   Reset clears the control state and loads the initial chaining value.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_PAD     = 9'b000000010,
    ST_LEN_LO  = 9'b000000100,
    ST_LEN_HI  = 9'b000001000,
    ST_CMP_P0  = 9'b000010000,
    ST_CMP_P1  = 9'b000100000,
    ST_CMP_RUN = 9'b001000000,
    ST_FIN     = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_e;

  localparam logic [3:0] LenLoIdx = 4'd14;
  localparam logic [3:0] LenHiIdx = 4'd15;
  localparam logic [5:0] LenLimit = 6'd56;
  localparam logic [5:0] LastStep = 6'd63;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  logic [31:0] cv_q [4];
  logic [31:0] cv_d [4];
  logic [31:0] wr_q [4];
  logic [31:0] wr_d [4];
  logic [31:0] pre_q, pre_d;
  logic [31:0] acc_q, acc_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  step_q, step_d;
  logic [15:0] vld_q, vld_d;
  logic [1:0]  oidx_q, oidx_d;

  // Block buffer memory
  logic [31:0] buf_mem [16];
  logic [31:0] rdata_q;
  logic        rvld_q;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] msg_word;

  logic        in_acc;
  logic        out_acc;
  logic [31:0] lane_byte;
  logic [31:0] lane_pad;
  logic [5:0]  pos_inc;
  logic [31:0] step_sum;
  logic [31:0] step_new_b;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign digest_word_o = cv_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 2'd3);

  assign lane_byte = acc_q | ({24'b0, data_byte_i} << {pos_q[1:0], 3'b000});
  assign lane_pad  = acc_q | ({24'b0, md5_pkg::PadByte} << {pos_q[1:0], 3'b000});
  assign pos_inc   = pos_q + 6'd1;

  // Never-written words of a block read as zero
  assign msg_word   = rvld_q ? rdata_q : 32'b0;
  assign step_sum   = pre_q + md5_pkg::round_fn(step_q[5:4], wr_q[1], wr_q[2], wr_q[3]);
  assign step_new_b = wr_q[1] + md5_pkg::rotl(step_sum, md5_pkg::ROT_TAB[{step_q[5:4],
                                                                           step_q[1:0]}]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= buf_mem[mem_raddr];
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cv_d      = cv_q;
    wr_d      = wr_q;
    pre_d     = pre_q;
    acc_d     = acc_q;
    len_d     = len_q;
    pos_d     = pos_q;
    step_d    = step_q;
    vld_d     = vld_q;
    oidx_d    = oidx_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q[5:2];
    mem_wdata = lane_byte;
    mem_raddr = md5_pkg::msg_idx(step_q + 6'd2);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_present_i) begin
            len_d = len_q + 64'd8;
            pos_d = pos_inc;
            if (pos_q[1:0] == 2'd3) begin
              mem_we             = 1'b1;
              vld_d[pos_q[5:2]]  = 1'b1;
              acc_d              = 32'b0;
            end else begin
              acc_d = lane_byte;
            end
            if (pos_inc == 6'd0) begin
              state_d = ST_CMP_P0;
              ret_d   = end_of_message_i ? ST_PAD : ST_IDLE;
            end else if (end_of_message_i) begin
              state_d = ST_PAD;
            end
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Write out the word holding the pad byte, partial or not
        mem_we            = 1'b1;
        mem_wdata         = lane_pad;
        vld_d[pos_q[5:2]] = 1'b1;
        acc_d             = 32'b0;
        pos_d             = pos_inc;
        if (pos_inc == 6'd0 || pos_inc > LenLimit) begin
          state_d = ST_CMP_P0;
          ret_d   = ST_LEN_LO;
        end else begin
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        mem_we          = 1'b1;
        mem_waddr       = LenLoIdx;
        mem_wdata       = len_q[31:0];
        vld_d[LenLoIdx] = 1'b1;
        state_d         = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        mem_we          = 1'b1;
        mem_waddr       = LenHiIdx;
        mem_wdata       = len_q[63:32];
        vld_d[LenHiIdx] = 1'b1;
        state_d         = ST_CMP_P0;
        ret_d           = ST_OUT;
      end
      ST_CMP_P0: begin
        wr_d      = cv_q;
        step_d    = 6'd0;
        mem_raddr = md5_pkg::msg_idx(6'd0);
        state_d   = ST_CMP_P1;
      end
      ST_CMP_P1: begin
        mem_raddr = md5_pkg::msg_idx(6'd1);
        pre_d     = wr_q[0] + msg_word + md5_pkg::SINE_TAB[0];
        state_d   = ST_CMP_RUN;
      end
      ST_CMP_RUN: begin
        // Pre-add for the next step: its a is this step's d
        pre_d   = wr_q[3] + msg_word + md5_pkg::SINE_TAB[step_q + 6'd1];
        wr_d[0] = wr_q[3];
        wr_d[1] = step_new_b;
        wr_d[2] = wr_q[1];
        wr_d[3] = wr_q[2];
        step_d  = step_q + 6'd1;
        if (step_q == LastStep) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 4; i++) begin
          cv_d[i] = cv_q[i] + wr_q[i];
        end
        vld_d   = 16'b0;
        state_d = ret_q;
      end
      ST_OUT: begin
        if (out_acc) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            cv_d    = md5_pkg::IV_TAB;
            len_d   = 64'b0;
            pos_d   = 6'd0;
            acc_d   = 32'b0;
            vld_d   = 16'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      cv_q    <= md5_pkg::IV_TAB;
      acc_q   <= 32'b0;
      len_q   <= 64'b0;
      pos_q   <= 6'd0;
      step_q  <= 6'd0;
      vld_q   <= 16'b0;
      oidx_q  <= 2'd0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cv_q    <= cv_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
      vld_q   <= vld_d;
      oidx_q  <= oidx_d;
      rvld_q  <= vld_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q  <= wr_d;
    pre_q <= pre_d;
  end

endmodule

// ----- sv/md5_chk.sv -----
// Port-level checker for the MD5 digest core, bound into md5_message_digest.
// Depends on md5_message_digest's port list only.
module md5_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [1:0]  word_index_o,
  input logic        last_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
                                   && $stable(word_index_o))
    else $error("digest word changed while stalled");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 2'd3)))
    else $error("last_word does not match word index");

  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest pending");

  a_idx_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 2'd1))
    else $error("digest words not in order");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_word_o |=> !out_valid_o && !in_stall_o)
    else $error("core not ready after last digest word");

endmodule

bind md5_message_digest md5_chk u_md5_chk (.*);

// ----- sim/md5_digest_checker.sv -----
`timescale 1ns / 1ps
// Digest checker for md5_message_digest: watches both valid/stall channels,
// runs its own MD5 over the accepted bytes and compares each digest word.
// Stand-alone; needs no package.
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [1:0] {WordA, WordB, WordC, WordD} digest_sel_e;

  typedef struct packed {
    logic [31:0] word;
    digest_sel_e sel;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] ChainInit [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam int unsigned ShiftAmt [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };
  localparam logic [7:0] PadOctet = 8'h80;

  logic [31:0]  chain [4];
  logic [31:0]  chunk [16];
  logic [31:0]  sine_k [64];
  logic [63:0]  bit_total;
  logic [5:0]   fill_pos;
  digest_word_t digest_due_q [$];
  digest_word_t due;

  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void restart_message();
    chain = ChainInit;
    foreach (chunk[i]) chunk[i] = '0;
    bit_total = '0;
    fill_pos = '0;
  endfunction

  function automatic void compress_chunk();
    logic [31:0] a, b, c, d, f, mix, spare;
    int unsigned k, s;
    int j;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (j = 0; j < 64; j++) begin
      case (j / 16)
        0: begin
          f = (b & c) | (~b & d);
          k = j;
        end
        1: begin
          f = (b & d) | (c & ~d);
          k = 1 + 5 * j;
        end
        2: begin
          f = b ^ c ^ d;
          k = 5 + 3 * j;
        end
        default: begin
          f = c ^ (b | ~d);
          k = 7 * j;
        end
      endcase
      s = ShiftAmt[(j / 16) * 4 + j % 4];
      mix = a + f + chunk[k[3:0]] + sine_k[j];
      spare = d;
      d = c;
      c = b;
      b = b + ((mix << s) | (mix >> (32 - s)));
      a = spare;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    foreach (chunk[i]) chunk[i] = '0;
  endfunction

  function automatic void put_octet(input logic [7:0] octet);
    chunk[fill_pos[5:2]][{fill_pos[1:0], 3'b000} +: 8] = octet;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_chunk();
  endfunction

  function automatic void absorb_word(input logic [7:0] octet, input logic present,
                                      input logic closing);
    digest_word_t dw;
    int k;
    if (present) begin
      bit_total = bit_total + 64'd8;
      put_octet(octet);
    end
    if (closing) begin
      put_octet(PadOctet);
      // no room left for the length: flush this chunk with zeros first
      if (fill_pos > 6'd56) compress_chunk();
      chunk[14] = bit_total[31:0];
      chunk[15] = bit_total[63:32];
      compress_chunk();
      for (k = 0; k < 4; k++) begin
        dw.word = chain[k];
        dw.sel  = digest_sel_e'(k);
        dw.last = (dw.sel == WordD);
        digest_due_q.push_back(dw);
      end
      restart_message();
    end
  endfunction

  initial begin
    real v;
    longint full;
    // sine constants: floor(|sin(i+1)| * 2^32)
    for (int i = 0; i < 64; i++) begin
      v = $sin(i + 1);
      if (v < 0.0) v = -v;
      full = longint'($floor(v * 4294967296.0));
      sine_k[i] = full[31:0];
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart_message();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_due_q.size() == 0) begin
          report_mismatch($sformatf("digest word %h with none due", digest_word_i));
        end else begin
          due = digest_due_q.pop_front();
          if (digest_word_i !== due.word)
            report_mismatch($sformatf("digest_word got %h want %h", digest_word_i, due.word));
          if (word_index_i !== due.sel)
            report_mismatch($sformatf("word_index got %0d want %0d", word_index_i, due.sel));
          if (last_word_i !== due.last)
            report_mismatch($sformatf("last_word got %b want %b", last_word_i, due.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        absorb_word(data_byte_i, byte_present_i, end_of_message_i);
      pending_o = digest_due_q.size();
    end
  end

endmodule

// ----- sim/md5_message_digest_tb.sv -----
`timescale 1ns / 1ps
// Top of the md5_message_digest testbench: clock, reset, byte stimulus,
// receiver stalls and verdict. Depends on md5_digest_checker and the block.
module md5_message_digest_tb;

  localparam int unsigned ItemTarget = 500;
  localparam int unsigned IdlePct    = 17;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 80;
  localparam int unsigned BoundaryLen [10] = '{
    55, 56, 57, 63, 64, 65, 119, 120, 127, 128
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  int fail_count;
  int pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  md5_message_digest uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_word_o   (digest_word_o),
    .word_index_o    (word_index_o),
    .last_word_o     (last_word_o)
  );

  md5_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_word_i   (digest_word_o),
    .word_index_i    (word_index_o),
    .last_word_i     (last_word_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input logic [7:0] octet, input logic present,
                            input logic closing);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= octet;
    byte_present_i   <= present;
    end_of_message_i <= closing;
    if (present || closing) items_sent++;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input bit empty_end);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) offer_word(8'($urandom), 1'b0, 1'b0);
      offer_word(8'($urandom), 1'b1, !empty_end && (i == len - 1));
    end
    if (empty_end || len == 0) offer_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int msg_count;
    msg_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty message
    offer_word(8'h00, 1'b0, 1'b1);
    // idle word, extremes of the byte, byte on the ending word
    offer_word(8'hff, 1'b0, 1'b0);
    offer_word(8'h00, 1'b1, 1'b0);
    offer_word(8'hff, 1'b1, 1'b0);
    offer_word(8'h5a, 1'b1, 1'b1);
    // bytes closed by an empty end
    offer_word(8'h80, 1'b1, 1'b0);
    offer_word(8'h7f, 1'b1, 1'b0);
    offer_word(8'h33, 1'b0, 1'b1);
    // one-byte message, then empty again after a digest
    offer_word(8'h01, 1'b1, 1'b1);
    offer_word(8'hc3, 1'b0, 1'b1);

    while (items_sent < ItemTarget) begin
      calm = (msg_count >= 6 && msg_count < 10);
      // hold the receiver off while this message's digest and the next message wait
      if (msg_count == 3) hold_req = 1'b1;
      if ($urandom_range(9) < 3) len = BoundaryLen[$urandom_range(9)];
      else len = $urandom_range(24);
      send_message(len, 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) offer_word(8'($urandom), 1'b0, 1'b0);
      msg_count++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
sv/md5_pkg.sv
sv/md5_message_digest.sv
sv/md5_chk.sv
sim/md5_digest_checker.sv
sim/md5_message_digest_tb.sv
